@@ rtl/core/mwsc_pkg.sv @@
// Shared types, constants and the motion-to-direction table of the
// mecanum wheel speed control block. No dependencies.
package mwsc_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int NUM_MOTIONS = 6;

  localparam int DELTA_W  = 16;
  localparam int TARGET_W = 9;
  localparam int STEP_W   = 5;
  localparam int DUTY_W   = 7;
  localparam int MOTION_W = 3;
  localparam int CODE_W   = 8;
  localparam int CFG_W    = TARGET_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [TARGET_W-1:0] TARGET_MIN   = TARGET_W'(1);
  localparam logic [TARGET_W-1:0] TARGET_MAX   = TARGET_W'(500);
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(100);
  localparam logic [STEP_W-1:0]   STEP_MIN     = STEP_W'(1);
  localparam logic [STEP_W-1:0]   STEP_MAX     = STEP_W'(20);
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(5);
  localparam logic [DUTY_W-1:0]   DUTY_MIN     = DUTY_W'(1);
  localparam logic [DUTY_W-1:0]   DUTY_CAP     = DUTY_W'(100);
  localparam logic [DUTY_W-1:0]   LIMIT_RESET  = DUTY_W'(100);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  // input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  typedef logic [MOTION_W-1:0] motion_t;
  localparam motion_t MOT_BRAKE      = 3'd0;
  localparam motion_t MOT_AHEAD      = 3'd1;
  localparam motion_t MOT_LEFT       = 3'd2;
  localparam motion_t MOT_RIGHT      = 3'd3;
  localparam motion_t MOT_TURN_LEFT  = 3'd4;
  localparam motion_t MOT_TURN_RIGHT = 3'd5;

  // bridge command, encoded as it leaves the block
  typedef enum logic [1:0] {
    DIR_BRAKE = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_t;

  typedef logic [DUTY_W-1:0] duty_t;

  // per-wheel control bundle handed to a wheel update slice
  typedef struct packed {
    dir_t                dir;
    logic [TARGET_W-1:0] target;
    logic [STEP_W-1:0]   step;
    duty_t               limit;
  } wheel_ctrl_t;

  typedef struct packed {
    dir_t    [NUM_WHEELS-1:0] drive;
    duty_t   [NUM_WHEELS-1:0] duty;
    logic                     moving;
    motion_t                  motion;
  } result_t;

  // wheel order: 0 lf, 1 lr, 2 rf, 3 rr
  function automatic dir_t dir_of(input motion_t m, input logic [1:0] w);
    dir_t d;
    d = DIR_BRAKE;
    case (m)
      MOT_AHEAD:      d = DIR_FWD;
      MOT_LEFT:       d = (w == 2'd0 || w == 2'd3) ? DIR_REV : DIR_FWD;
      MOT_RIGHT:      d = (w == 2'd0 || w == 2'd3) ? DIR_FWD : DIR_REV;
      MOT_TURN_LEFT:  d = (w[1] == 1'b0) ? DIR_REV : DIR_FWD;
      MOT_TURN_RIGHT: d = (w[1] == 1'b0) ? DIR_FWD : DIR_REV;
      default:        d = DIR_BRAKE;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/mecanum_wheel_step_speed_control_unit.sv @@
// Each result is written to the result register, or to the skid register while
// the output stalls. Throughput: one beat per cycle while the skid is empty; all
// four wheels update side by side in one pass of add, compare and clamp logic
// ahead of the result register. A two-deep output stage (result register plus
// skid) keeps input open while one result waits. Synchronous active-low reset:
// motion brake, duties zero, registers at their defaults, output empty.
module mecanum_wheel_step_speed_control_unit import mwsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [CODE_W-1:0]          in_motion_code,
  input  logic signed [DELTA_W-1:0]  in_enc_delta_lf,
  input  logic signed [DELTA_W-1:0]  in_enc_delta_lr,
  input  logic signed [DELTA_W-1:0]  in_enc_delta_rf,
  input  logic signed [DELTA_W-1:0]  in_enc_delta_rr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_drive_lf,
  output logic [1:0]                 out_drive_lr,
  output logic [1:0]                 out_drive_rf,
  output logic [1:0]                 out_drive_rr,
  output logic [DUTY_W-1:0]          out_duty_lf,
  output logic [DUTY_W-1:0]          out_duty_lr,
  output logic [DUTY_W-1:0]          out_duty_rf,
  output logic [DUTY_W-1:0]          out_duty_rr,
  output logic                       out_moving_flag,
  output logic [MOTION_W-1:0]        out_current_motion,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  logic [TARGET_W-1:0] target_r;
  logic [STEP_W-1:0]   step_r;
  duty_t               limit_r;
  motion_t             motion_r, motion_nxt;
  duty_t               duty_r   [NUM_WHEELS];
  duty_t               duty_nxt [NUM_WHEELS];
  duty_t               wheel_duty [NUM_WHEELS];
  logic signed [DELTA_W-1:0] delta [NUM_WHEELS];

  result_t res_nxt, out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    accept;

  logic [TARGET_W-1:0] wr_target;
  logic [STEP_W-1:0]   wr_step;
  duty_t               wr_limit;
  motion_t             code_eff;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid_r;

  assign delta[0] = in_enc_delta_lf;
  assign delta[1] = in_enc_delta_lr;
  assign delta[2] = in_enc_delta_rf;
  assign delta[3] = in_enc_delta_rr;

  // ---------------- configuration ----------------
  assign wr_target = (cfg_wdata < TARGET_MIN) ? TARGET_MIN :
                     (cfg_wdata > TARGET_MAX) ? TARGET_MAX : cfg_wdata;
  assign wr_step   = (cfg_wdata[STEP_W-1:0] < STEP_MIN) ? STEP_MIN :
                     (cfg_wdata[STEP_W-1:0] > STEP_MAX) ? STEP_MAX : cfg_wdata[STEP_W-1:0];
  assign wr_limit  = (cfg_wdata[DUTY_W-1:0] < DUTY_MIN) ? DUTY_MIN :
                     (cfg_wdata[DUTY_W-1:0] > DUTY_CAP) ? DUTY_CAP : cfg_wdata[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      step_r   <= STEP_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: target_r <= wr_target;
        REG_STEP:   step_r   <= wr_step;
        REG_LIMIT:  limit_r  <= wr_limit;
        default: ;
      endcase
    end
  end

  // ---------------- wheel slices ----------------
  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
    wheel_ctrl_t ctrl;
    assign ctrl.dir    = dir_of(motion_r, 2'(w));
    assign ctrl.target = target_r;
    assign ctrl.step   = step_r;
    assign ctrl.limit  = limit_r;

    mwsc_wheel u_wheel (
      .ctrl     (ctrl),
      .delta    (delta[w]),
      .duty     (duty_r[w]),
      .duty_nxt (wheel_duty[w])
    );
  end

  // ---------------- item decode ----------------
  assign code_eff = (in_motion_code > CODE_W'(MOT_TURN_RIGHT))
                  ? MOT_BRAKE : in_motion_code[MOTION_W-1:0];

  always_comb begin
    motion_nxt     = motion_r;
    res_nxt.moving = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      duty_nxt[i]      = duty_r[i];
      res_nxt.drive[i] = DIR_BRAKE;
    end
    if (in_action == ACT_SET) begin
      if (code_eff == motion_r) begin
        res_nxt.moving = (code_eff != MOT_BRAKE);
      end else begin
        // new motion: brake everything and restart from zero duty
        motion_nxt     = code_eff;
        res_nxt.moving = 1'b1;
        for (int i = 0; i < NUM_WHEELS; i++) duty_nxt[i] = '0;
      end
    end else begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        duty_nxt[i]      = wheel_duty[i];
        res_nxt.drive[i] = dir_of(motion_r, 2'(i));
      end
    end
    for (int i = 0; i < NUM_WHEELS; i++) res_nxt.duty[i] = duty_nxt[i];
    res_nxt.motion = motion_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r <= MOT_BRAKE;
      for (int i = 0; i < NUM_WHEELS; i++) duty_r[i] <= '0;
    end else if (accept) begin
      motion_r <= motion_nxt;
      for (int i = 0; i < NUM_WHEELS; i++) duty_r[i] <= duty_nxt[i];
    end
  end

  // ---------------- output register + skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || out_ready) out_r <= res_nxt;
      else                           skid_r <= res_nxt;
    end else if (out_ready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_lf       = out_r.drive[0];
  assign out_drive_lr       = out_r.drive[1];
  assign out_drive_rf       = out_r.drive[2];
  assign out_drive_rr       = out_r.drive[3];
  assign out_duty_lf        = out_r.duty[0];
  assign out_duty_lr        = out_r.duty[1];
  assign out_duty_rf        = out_r.duty[2];
  assign out_duty_rr        = out_r.duty[3];
  assign out_moving_flag    = out_r.moving;
  assign out_current_motion = out_r.motion;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_brake_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (motion_r == MOT_BRAKE) |-> (duty_r[0] == '0 && duty_r[1] == '0 &&
                                 duty_r[2] == '0 && duty_r[3] == '0))
    else $error("nonzero duty while braking");

  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r[0] <= DUTY_CAP && duty_r[1] <= DUTY_CAP &&
    duty_r[2] <= DUTY_CAP && duty_r[3] <= DUTY_CAP)
    else $error("wheel duty above cap");

  a_new_motion_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_SET && code_eff != motion_r) |=>
      (duty_r[0] == '0 && duty_r[1] == '0 && duty_r[2] == '0 && duty_r[3] == '0))
    else $error("duties not cleared on motion change");

endmodule

@@ rtl/core/mwsc_wheel.sv @@
// One wheel's duty update: sign correction, compare against target, step
// and clamp; braking forces zero duty. Depends on mwsc_pkg.
module mwsc_wheel import mwsc_pkg::*; (
  input  wheel_ctrl_t              ctrl,
  input  logic signed [DELTA_W-1:0] delta,
  input  duty_t                    duty,
  output duty_t                    duty_nxt
);

  logic signed [DELTA_W-1:0] meas;
  logic signed [DELTA_W-1:0] target_s;
  logic [DUTY_W:0]           sum_up;

  // -32768 negates to itself in 16 bits, which is the wanted wrap
  assign meas     = (ctrl.dir == DIR_REV) ? -delta : delta;
  assign target_s = $signed({{(DELTA_W-TARGET_W){1'b0}}, ctrl.target});
  assign sum_up   = {1'b0, duty} + {{(DUTY_W+1-STEP_W){1'b0}}, ctrl.step};

  always_comb begin
    duty_nxt = duty;
    if (ctrl.dir == DIR_BRAKE) begin
      duty_nxt = '0;
    end else if (meas < target_s) begin
      duty_nxt = (sum_up > {1'b0, ctrl.limit}) ? ctrl.limit : sum_up[DUTY_W-1:0];
    end else if (meas > target_s) begin
      duty_nxt = (duty > {{(DUTY_W-STEP_W){1'b0}}, ctrl.step})
               ? duty - {{(DUTY_W-STEP_W){1'b0}}, ctrl.step} : '0;
    end
  end

endmodule
